>>> hw/rtl/cme_pkg.sv
// ----------------------------------------------------------------------------
// cme_pkg
// Shared constants for the character modular exponentiation block:
// control register port index width, register indexes and character width.
// ----------------------------------------------------------------------------
package cme_pkg;

   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_A = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_B = 2'd1;

   localparam int CHAR_WIDTH = 8;

endpackage

>>> hw/rtl/char_modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// char_modular_exponentiation_top
// Exact char_code ^ exponent mod modulus, bit-serial square-and-multiply.
//
// Channels: a command is taken at a clock edge where start is high and busy
// is low; req_char_code is sampled there. The result appears on
// rsp_cipher_value for exactly one cycle with rsp_valid high; the receiver
// cannot stall it. Keys are written through csr_we / csr_index / csr_wdata:
// index 0 is key_a, index 1 is key_b, other indexes are dropped. The smaller
// key is the exponent, the larger the modulus. Write keys only while idle.
// Operation: one modular multiply is a shift-and-add over the multiplier
// bits, one bit per cycle, ending in a retire step. An item is loaded, the
// character is reduced modulo the modulus one bit at a time, then each
// exponent bit, lowest first, takes an exponent-bit step plus one squaring
// and, for a set bit, one more multiply. A modulus below 2 gives 0 and busy
// stays low. Busy drops in the cycle of the result strobe, so the next
// command can be taken at the edge that ends that cycle. Reset returns keys
// to 17 and 3233 and drops any item in flight.
// ----------------------------------------------------------------------------
module char_modular_exponentiation_top #(
   parameter int KEY_WIDTH = 31
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [cme_pkg::CHAR_WIDTH-1:0]       req_char_code,
   output logic                                 rsp_valid,
   output logic [KEY_WIDTH-1:0]                 rsp_cipher_value,
   input  logic                                 csr_we,
   input  logic [cme_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [KEY_WIDTH-1:0]                 csr_wdata
);

   localparam int SW = KEY_WIDTH + 1;
   localparam int CW = $clog2(cme_pkg::CHAR_WIDTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_EXPBIT,
      ST_MUL
   } state_type;

   state_type                      state_ff, state_in;
   logic [KEY_WIDTH-1:0]           key_a_ff, key_b_ff;
   logic [KEY_WIDTH-1:0]           exp_ff, exp_in;
   logic [KEY_WIDTH-1:0]           mod_ff, mod_in;
   logic [KEY_WIDTH-1:0]           base_ff, base_in;
   logic [KEY_WIDTH-1:0]           res_ff, res_in;
   logic [KEY_WIDTH-1:0]           mul_a_ff, mul_a_in;
   logic [KEY_WIDTH-1:0]           mul_b_ff, mul_b_in;
   logic [KEY_WIDTH-1:0]           acc_ff, acc_in;
   logic                           to_res_ff, to_res_in;
   logic [CW-1:0]                  cnt_ff, cnt_in;
   logic [cme_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0]           rsp_value_ff, rsp_value_in;

   logic                           key_a_lt;
   logic [KEY_WIDTH-1:0]           sel_exp, sel_mod;
   logic [SW-1:0]                  sum_acc, sum_dbl, sum_red;
   logic [KEY_WIDTH-1:0]           acc_add, a_dbl, red_next;

   assign key_a_lt = key_a_ff < key_b_ff;
   assign sel_exp  = key_a_lt ? key_a_ff : key_b_ff;
   assign sel_mod  = key_a_lt ? key_b_ff : key_a_ff;

   assign sum_acc  = {1'b0, acc_ff} + {1'b0, mul_a_ff};
   assign sum_dbl  = {mul_a_ff, 1'b0};
   assign sum_red  = {acc_ff, char_ff[cnt_ff]};

   assign acc_add  = (sum_acc >= {1'b0, mod_ff}) ?
                     KEY_WIDTH'(sum_acc - {1'b0, mod_ff}) : KEY_WIDTH'(sum_acc);
   assign a_dbl    = (sum_dbl >= {1'b0, mod_ff}) ?
                     KEY_WIDTH'(sum_dbl - {1'b0, mod_ff}) : KEY_WIDTH'(sum_dbl);
   assign red_next = (sum_red >= {1'b0, mod_ff}) ?
                     KEY_WIDTH'(sum_red - {1'b0, mod_ff}) : KEY_WIDTH'(sum_red);

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      mod_in       = mod_ff;
      base_in      = base_ff;
      res_in       = res_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      acc_in       = acc_ff;
      to_res_in    = to_res_ff;
      cnt_in       = cnt_ff;
      char_in      = char_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               exp_in  = sel_exp;
               mod_in  = sel_mod;
               char_in = req_char_code;
               acc_in  = '0;
               cnt_in  = CW'(cme_pkg::CHAR_WIDTH - 1);
               if (sel_mod < KEY_WIDTH'(2)) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = '0;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            acc_in = red_next;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               base_in  = red_next;
               res_in   = KEY_WIDTH'(1);
               state_in = ST_EXPBIT;
            end
         end
         ST_EXPBIT: begin
            acc_in = '0;
            if (exp_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end else if (exp_ff[0]) begin
               mul_a_in  = res_ff;
               mul_b_in  = base_ff;
               to_res_in = 1'b1;
               state_in  = ST_MUL;
            end else begin
               mul_a_in  = base_ff;
               mul_b_in  = base_ff;
               to_res_in = 1'b0;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_b_ff == '0) begin
               if (to_res_ff) begin
                  res_in    = acc_ff;
                  mul_a_in  = base_ff;
                  mul_b_in  = base_ff;
                  acc_in    = '0;
                  to_res_in = 1'b0;
               end else begin
                  base_in  = acc_ff;
                  exp_in   = exp_ff >> 1;
                  state_in = ST_EXPBIT;
               end
            end else begin
               if (mul_b_ff[0]) begin
                  acc_in = acc_add;
               end
               mul_a_in = a_dbl;
               mul_b_in = mul_b_ff >> 1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         key_a_ff     <= KEY_WIDTH'(17);
         key_b_ff     <= KEY_WIDTH'(3233);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == cme_pkg::CSR_KEY_A) begin
            key_a_ff <= csr_wdata;
         end
         if (csr_we && csr_index == cme_pkg::CSR_KEY_B) begin
            key_b_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      exp_ff       <= exp_in;
      mod_ff       <= mod_in;
      base_ff      <= base_in;
      res_ff       <= res_in;
      mul_a_ff     <= mul_a_in;
      mul_b_ff     <= mul_b_in;
      acc_ff       <= acc_in;
      to_res_ff    <= to_res_in;
      cnt_ff       <= cnt_in;
      char_ff      <= char_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cipher_value = rsp_value_ff;

   a_result_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((mod_ff < KEY_WIDTH'(2)) ? (rsp_cipher_value == '0)
                                              : (rsp_cipher_value < mod_ff)))
      else $error("result not reduced modulo the modulus");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted command neither started nor answered");

   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (acc_ff < mod_ff && mul_a_ff < mod_ff))
      else $error("multiplier operand escaped the modulus");

endmodule

>>> tb/char_modular_exponentiation_top_tb.sv
// ----------------------------------------------------------------------------
// char_modular_exponentiation_top_tb
// Drives character commands through the exponentiation block under changing
// key settings and sender idle patterns. Each transfer is scored against an
// exact square-and-multiply prediction made from shadow copies of the keys.
// ----------------------------------------------------------------------------
module char_modular_exponentiation_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W = 31;
   localparam int CHAR_W = cme_pkg::CHAR_WIDTH;
   localparam int IDX_W = cme_pkg::CSR_INDEX_WIDTH;
   localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
   localparam logic [IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [KEY_W-1:0] RESET_KEY_A = 31'd17;
   localparam logic [KEY_W-1:0] RESET_KEY_B = 31'd3233;
   localparam int CYCLE_LIMIT = 2_500_000;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 2200;
   localparam int RANDOM_SETTINGS = 10;
   localparam int ITEMS_PER_SETTING = 27;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic rsp_valid;
   logic [KEY_W-1:0] rsp_cipher_value;
   logic csr_we = 1'b0;
   logic [IDX_W-1:0] csr_index = '0;
   logic [KEY_W-1:0] csr_wdata = '0;

   logic [KEY_W-1:0] key_a_shadow = RESET_KEY_A;
   logic [KEY_W-1:0] key_b_shadow = RESET_KEY_B;
   logic [KEY_W-1:0] cipher_expected_q[$];
   int fail_count = 0;
   int cycle_count = 0;
   int idle_pct = 0;

   char_modular_exponentiation_top #(
      .KEY_WIDTH(KEY_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_cipher_value (rsp_cipher_value),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [KEY_W-1:0] cipher_of(input logic [CHAR_W-1:0] ch,
                                                  input logic [KEY_W-1:0] ka,
                                                  input logic [KEY_W-1:0] kb);
      logic [63:0] modulus;
      logic [63:0] power;
      logic [63:0] base;
      logic [63:0] acc;
      modulus = (ka < kb) ? 64'(kb) : 64'(ka);
      power = (ka < kb) ? 64'(ka) : 64'(kb);
      if (modulus < 64'd2)
         return '0;
      base = 64'(ch) % modulus;
      acc = 64'd1;
      while (power != 64'd0) begin
         if (power[0])
            acc = (acc * base) % modulus;
         base = (base * base) % modulus;
         power = power >> 1;
      end
      return acc[KEY_W-1:0];
   endfunction

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("char_modular_exponentiation_top regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin : score_cipher
      logic [KEY_W-1:0] expected_cipher;
      if (reset) begin
         key_a_shadow = RESET_KEY_A;
         key_b_shadow = RESET_KEY_B;
      end else begin
         if (rsp_valid) begin
            if (cipher_expected_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected cipher transfer: expected none, actual %0d",
                        $time, rsp_cipher_value);
            end else begin
               expected_cipher = cipher_expected_q.pop_front();
               if (rsp_cipher_value !== expected_cipher) begin
                  fail_count++;
                  $display("%0t: cipher_value mismatch: expected %0d, actual %0d",
                           $time, expected_cipher, rsp_cipher_value);
               end
            end
         end
         if (start && !busy)
            cipher_expected_q.push_back(cipher_of(req_char_code, key_a_shadow,
                                                  key_b_shadow));
         if (csr_we) begin
            case (csr_index)
               cme_pkg::CSR_KEY_A: key_a_shadow = csr_wdata;
               cme_pkg::CSR_KEY_B: key_b_shadow = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   task automatic send_char(input logic [CHAR_W-1:0] ch);
      int gap;
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         do @(posedge clock); while (busy);
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_char_code = ch;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_ciphers();
      @(negedge clock);
      start = 1'b0;
      while (cipher_expected_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_key(input logic [IDX_W-1:0] index,
                            input logic [KEY_W-1:0] value);
      @(negedge clock);
      start = 1'b0;
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_keys(input logic [KEY_W-1:0] ka, input logic [KEY_W-1:0] kb);
      drain_ciphers();
      write_key(cme_pkg::CSR_KEY_A, ka);
      write_key(cme_pkg::CSR_KEY_B, kb);
   endtask

   task automatic test_reset_keys();
      send_char(8'd0);
      send_char(8'd1);
      send_char(8'd255);
      send_char(8'd65);
   endtask

   task automatic test_degenerate_moduli();
      set_keys('0, '0);
      send_char(8'd0);
      send_char(8'd200);
      set_keys(31'd1, '0);
      send_char(8'd7);
      set_keys('0, 31'd1);
      send_char(8'd0);
   endtask

   task automatic test_zero_exponent();
      set_keys(31'd1000, '0);
      send_char(8'd0);
      send_char(8'd99);
   endtask

   task automatic test_wide_characters();
      set_keys(31'd5, 31'd3);
      send_char(8'd255);
      send_char(8'd5);
      send_char(8'd4);
   endtask

   task automatic test_equal_keys();
      set_keys(31'd2, 31'd2);
      send_char(8'd3);
      send_char(8'd255);
   endtask

   task automatic test_key_extremes();
      set_keys(KEY_MAX, KEY_MAX - 31'd1);
      send_char(8'd255);
      send_char(8'd2);
      set_keys(KEY_MAX, KEY_MAX);
      send_char(8'd254);
      set_keys(31'd2, 31'd3);
      send_char(8'd128);
   endtask

   task automatic test_spare_indexes();
      set_keys(31'd3233, 31'd17);
      write_key(CSR_SPARE_2, KEY_MAX);
      write_key(CSR_SPARE_3, 31'h2AAA_AAAA);
      send_char(8'h41);
      send_char(8'hBE);
   endtask

   task automatic test_random_keys();
      logic [KEY_W-1:0] power_key;
      logic [KEY_W-1:0] modulus_key;
      int pick;
      for (int setting = 0; setting < RANDOM_SETTINGS; setting++) begin
         pick = $urandom_range(99);
         if (pick < 60)
            power_key = KEY_W'($urandom_range(2, 255));
         else if (pick < 85)
            power_key = KEY_W'($urandom_range(256, 65535));
         else
            power_key = KEY_W'($urandom());
         pick = $urandom_range(99);
         if (pick < 20)
            modulus_key = KEY_W'($urandom_range(2, 300));
         else if (pick < 30)
            modulus_key = power_key;
         else
            modulus_key = KEY_W'($urandom());
         if ($urandom_range(1))
            set_keys(power_key, modulus_key);
         else
            set_keys(modulus_key, power_key);
         case (setting % 3)
            0: idle_pct = 0;
            1: idle_pct = 45;
            default: idle_pct = 24;
         endcase
         for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if ($urandom_range(19) == 0)
               drain_ciphers();
            send_char(CHAR_W'($urandom_range(0, 255)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_keys();
      test_degenerate_moduli();
      test_zero_exponent();
      test_wide_characters();
      test_equal_keys();
      test_key_extremes();
      test_spare_indexes();
      test_random_keys();

      drain_ciphers();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (cipher_expected_q.size() != 0)
         $display("%0t: ciphers still pending: expected 0, actual %0d",
                  $time, cipher_expected_q.size());
      if (fail_count == 0 && cipher_expected_q.size() == 0) begin
         $display("char_modular_exponentiation_top regression: pass");
      end else begin
         $display("char_modular_exponentiation_top regression: fail");
      end
      $finish;
   end

endmodule
